// File: src/gsv_pkg.sv
// shared types, constants and helpers for the gsv satellite table
package gsv_pkg;

  localparam int TableEntries      = 32;
  localparam int GroupsPerSentence = 4;
  localparam int IdxW              = $clog2(TableEntries);
  localparam int CntW              = IdxW + 1;

  localparam logic [9:0]  AccMax     = 10'd999;
  localparam logic [31:0] TimeoutRst = 32'd30000;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;

  localparam logic [2:0] ConsUnknown = 3'd0;
  localparam logic [2:0] ConsGps     = 3'd1;
  localparam logic [2:0] ConsGlonass = 3'd2;
  localparam logic [2:0] ConsGalileo = 3'd3;
  localparam logic [2:0] ConsBeidou  = 3'd4;
  localparam logic [2:0] ConsQzss    = 3'd5;

  localparam logic EvUpdate = 1'b0;
  localparam logic EvEvict  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] prn;
    logic       elev_ok;
    logic [6:0] elevation;
    logic       azim_ok;
    logic [8:0] azimuth;
    logic       snr_ok;
    logic [9:0] snr;
    logic [2:0] constellation;
  } commit_t;

  typedef struct packed {
    logic [7:0]  prn;
    logic [6:0]  elevation;
    logic [8:0]  azimuth;
    logic [9:0]  snr;
    logic [2:0]  constellation;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic            event_res;
    logic [IdxW-1:0] slot;
    logic [7:0]      prn;
    logic [6:0]      elevation;
    logic [8:0]      azimuth;
    logic [9:0]      snr;
    logic [2:0]      constellation;
    logic            last;
  } result_t;

  // talker prefix lookup over the five characters after the dollar
  function automatic logic [2:0] talker_code(input logic [39:0] s);
    logic [2:0] code;
    code = ConsUnknown;
    case (s)
      "GPGSV": code = ConsGps;
      "GLGSV": code = ConsGlonass;
      "GAGSV": code = ConsGalileo;
      "BDGSV": code = ConsBeidou;
      "QZGSV": code = ConsQzss;
      default: code = ConsUnknown;
    endcase
    return code;
  endfunction

endpackage

// File: src/gsv_parser.sv
// byte-level gsv sentence parser producing one group commit request
module gsv_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       char_i,
  output gsv_pkg::commit_t req_o
);
  import gsv_pkg::*;

  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhHeader = 4'b0010,
    PhGroups = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  char_pos_q, char_pos_d;
  logic [7:0]  pbuf_q [4], pbuf_d [4];
  logic [2:0]  prefix_q, prefix_d;
  logic [2:0]  comma_q, comma_d;
  logic [2:0]  gcount_q, gcount_d;
  logic [1:0]  fidx_q, fidx_d;
  logic [3:0]  present_q, present_d;
  logic [9:0]  gv_q [4], gv_d [4];
  logic [9:0]  acc_q, acc_d;
  logic        nonempty_q, nonempty_d;
  logic        neg_q, neg_d;
  logic        stop_q, stop_d;

  logic [13:0] acc_next;
  logic        field_ok;
  logic [3:0]  mask;
  commit_t     req;

  assign acc_next = {4'b0, acc_q} * 14'd10 + {6'b0, char_i - Ch0};
  assign field_ok = nonempty_q && !(neg_q && acc_q != '0);

  always_comb begin
    phase_d    = phase_q;
    char_pos_d = char_pos_q;
    pbuf_d     = pbuf_q;
    prefix_d   = prefix_q;
    comma_d    = comma_q;
    gcount_d   = gcount_q;
    fidx_d     = fidx_q;
    present_d  = present_q;
    gv_d       = gv_q;
    acc_d      = acc_q;
    nonempty_d = nonempty_q;
    neg_d      = neg_q;
    stop_d     = stop_q;
    mask       = present_q;
    req        = '0;

    if (byte_valid_i) begin
      if (char_i == ChDollar) begin
        phase_d    = PhHeader;
        prefix_d   = ConsUnknown;
        char_pos_d = '0;
        comma_d    = '0;
        gcount_d   = '0;
        fidx_d     = '0;
        present_d  = '0;
        for (int i = 0; i < 4; i++) gv_d[i] = '0;
        acc_d      = '0;
        nonempty_d = 1'b0;
        neg_d      = 1'b0;
        stop_d     = 1'b0;
      end else if (char_i == ChLf) begin
        phase_d = PhIdle;
      end else if (phase_q == PhHeader || phase_q == PhGroups) begin
        if (char_pos_q < 3'd5) begin
          char_pos_d = char_pos_q + 3'd1;
          if (char_pos_q == 3'd4) begin
            prefix_d = talker_code({pbuf_q[0], pbuf_q[1], pbuf_q[2], pbuf_q[3], char_i});
          end else begin
            pbuf_d[char_pos_q[1:0]] = char_i;
          end
        end
        case (phase_q)
          PhHeader: begin
            if (char_i == ChStar) begin
              phase_d = PhDone;
            end else if (char_i == ChComma) begin
              comma_d = comma_q + 3'd1;
              if (comma_q >= 3'd3) begin
                phase_d    = PhGroups;
                fidx_d     = '0;
                present_d  = '0;
                acc_d      = '0;
                nonempty_d = 1'b0;
                neg_d      = 1'b0;
                stop_d     = 1'b0;
              end
            end
          end
          PhGroups: begin
            if (char_i == ChComma || char_i == ChStar) begin
              if (fidx_q == 2'd0 && !nonempty_q && char_i == ChStar) begin
                phase_d = PhDone;
              end else begin
                gv_d[fidx_q] = acc_q;
                if (field_ok) mask[fidx_q] = 1'b1;
                present_d = mask;
                if (fidx_q == 2'd3) begin
                  // snr field closes the group
                  req.valid = mask[0] && gv_q[0] >= 10'd1 && gv_q[0] <= 10'd199;
                  req.prn           = gv_q[0][7:0];
                  req.elev_ok       = mask[1] && gv_q[1] <= 10'd90;
                  req.elevation     = gv_q[1][6:0];
                  req.azim_ok       = mask[2] && gv_q[2] < 10'd360;
                  req.azimuth       = gv_q[2][8:0];
                  req.snr_ok        = mask[3];
                  req.snr           = acc_q;
                  req.constellation = prefix_q;
                  gcount_d  = gcount_q + 3'd1;
                  fidx_d    = '0;
                  present_d = '0;
                  if (char_i == ChStar || gcount_q + 3'd1 >= 3'(GroupsPerSentence)) begin
                    phase_d = PhDone;
                  end
                end else begin
                  fidx_d = fidx_q + 2'd1;
                  if (char_i == ChStar) phase_d = PhDone;
                end
                acc_d      = '0;
                nonempty_d = 1'b0;
                neg_d      = 1'b0;
                stop_d     = 1'b0;
              end
            end else begin
              if (!nonempty_q && char_i == ChMinus) begin
                neg_d = 1'b1;
              end else if (!stop_q && char_i >= Ch0 && char_i <= Ch9) begin
                acc_d = (acc_next > 14'(AccMax)) ? AccMax : acc_next[9:0];
              end else begin
                stop_d = 1'b1;
              end
              nonempty_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      char_pos_q <= '0;
      prefix_q   <= ConsUnknown;
      comma_q    <= '0;
      gcount_q   <= '0;
      fidx_q     <= '0;
      present_q  <= '0;
      acc_q      <= '0;
      nonempty_q <= 1'b0;
      neg_q      <= 1'b0;
      stop_q     <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pbuf_q[i] <= '0;
        gv_q[i]   <= '0;
      end
    end else begin
      phase_q    <= phase_d;
      char_pos_q <= char_pos_d;
      prefix_q   <= prefix_d;
      comma_q    <= comma_d;
      gcount_q   <= gcount_d;
      fidx_q     <= fidx_d;
      present_q  <= present_d;
      acc_q      <= acc_d;
      nonempty_q <= nonempty_d;
      neg_q      <= neg_d;
      stop_q     <= stop_d;
      pbuf_q     <= pbuf_d;
      gv_q       <= gv_d;
    end
  end

endmodule

// File: src/gsv_table.sv
// slot memory with search-and-update and stale sweep sequencer
module gsv_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_scan_i,
  input  logic             start_tick_i,
  input  gsv_pkg::commit_t req_i,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_data_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output gsv_pkg::result_t res_o
);
  import gsv_pkg::*;

  typedef enum logic [2:0] {
    TbIdle  = 3'b001,
    TbScan  = 3'b010,
    TbSweep = 3'b100
  } tb_state_e;

  tb_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ph_vld_q, ph_vld_d;
  logic [IdxW-1:0] ph_idx_q, ph_idx_d;
  commit_t         req_q;
  logic [31:0]     time_q, timeout_q;
  logic            vld_q [TableEntries];
  logic            rd_vld_q;
  entry_t          rd_data_q;
  entry_t          mem [TableEntries];

  logic            pend_vld_q, pend_vld_d;
  result_t         pend_q, pend_d;
  logic            out_vld_q, out_vld_d;
  result_t         out_q, out_d;

  logic            issue, hit, stale, done;
  logic            wr_en;
  entry_t          cur, wr_data;
  logic [31:0]     age;

  assign cur   = rd_vld_q ? rd_data_q : '0;
  assign age   = time_q - cur.stamp;
  assign issue = (state_q != TbIdle) && (cnt_q < CntW'(TableEntries));
  assign hit   = (state_q == TbScan) && ph_vld_q &&
                 (cur.prn == req_q.prn || cur.prn == '0);
  assign stale = (state_q == TbSweep) && ph_vld_q && cur.prn != '0 && age > timeout_q;
  assign done  = !issue && !ph_vld_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = issue ? cnt_q + CntW'(1) : cnt_q;
    ph_vld_d   = issue && !hit;
    ph_idx_d   = cnt_q[IdxW-1:0];
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = 1'b0;
    out_d      = out_q;
    wr_en      = 1'b0;
    wr_data    = cur;

    case (state_q)
      TbIdle: begin
        if (start_scan_i) begin
          state_d = TbScan;
          cnt_d   = '0;
        end else if (start_tick_i) begin
          state_d = TbSweep;
          cnt_d   = '0;
        end
      end
      TbScan: begin
        if (hit) begin
          wr_en                 = 1'b1;
          wr_data.prn           = req_q.prn;
          if (req_q.elev_ok) wr_data.elevation = req_q.elevation;
          if (req_q.azim_ok) wr_data.azimuth = req_q.azimuth;
          if (req_q.snr_ok) wr_data.snr = req_q.snr;
          wr_data.constellation = req_q.constellation;
          wr_data.stamp         = time_q;
          out_vld_d             = 1'b1;
          out_d = '{event_res: EvUpdate, slot: ph_idx_q, prn: wr_data.prn,
                    elevation: wr_data.elevation, azimuth: wr_data.azimuth,
                    snr: wr_data.snr, constellation: wr_data.constellation, last: 1'b1};
          state_d = TbIdle;
        end else if (done) begin
          state_d = TbIdle;
        end
      end
      TbSweep: begin
        if (stale) begin
          wr_en       = 1'b1;
          wr_data.prn = '0;
          // hold each eviction back one step so the final one can carry last
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = pend_q;
          end
          pend_vld_d = 1'b1;
          pend_d = '{event_res: EvEvict, slot: ph_idx_q, prn: 8'd0,
                     elevation: cur.elevation, azimuth: cur.azimuth, snr: cur.snr,
                     constellation: cur.constellation, last: 1'b0};
        end else if (done) begin
          state_d = TbIdle;
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_vld_d = 1'b0;
          end
        end
      end
      default: state_d = TbIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[ph_idx_q] <= wr_data;
    rd_data_q <= mem[cnt_q[IdxW-1:0]];
    if (start_scan_i) req_q <= req_i;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= TbIdle;
      cnt_q      <= '0;
      ph_vld_q   <= 1'b0;
      ph_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      time_q     <= '0;
      timeout_q  <= TimeoutRst;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < TableEntries; i++) vld_q[i] <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ph_vld_q   <= ph_vld_d;
      ph_idx_q   <= ph_idx_d;
      rd_vld_q   <= vld_q[cnt_q[IdxW-1:0]];
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (wr_en) vld_q[ph_idx_q] <= 1'b1;
      if (state_q == TbIdle && start_tick_i && !start_scan_i) time_q <= time_q + 32'd1;
      if (cfg_we_i) timeout_q <= cfg_data_i;
    end
  end

  assign busy_o      = (state_q != TbIdle);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: src/gsv_satellite_table.sv
// top level: gsv sentence parser feeding a 32-slot satellite table
// A byte is taken whenever start is high and busy is low; a byte that completes a storable group, and every
// millisecond tick, starts a walk over the slot memory with one read per slot,
// during which busy is high.
// Results appear on valid_o for one cycle each and must be taken when shown.
module gsv_satellite_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [7:0]  char_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic        event_res_o,
  output logic [4:0]  slot_o,
  output logic [7:0]  prn_o,
  output logic [6:0]  elevation_o,
  output logic [8:0]  azimuth_o,
  output logic [9:0]  snr_o,
  output logic [2:0]  constellation_o,
  output logic        last_o
);
  import gsv_pkg::*;

  logic    accept;
  logic    tb_busy;
  commit_t req;
  result_t res;

  assign accept      = start && !tb_busy;
  assign cfg_ready_o = 1'b1;

  gsv_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept && !kind_i),
    .char_i       (char_in_i),
    .req_o        (req)
  );

  gsv_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_scan_i (accept && !kind_i && req.valid),
    .start_tick_i (accept && kind_i),
    .req_i        (req),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .busy_o       (tb_busy),
    .res_valid_o  (valid_o),
    .res_o        (res)
  );

  assign busy            = tb_busy;
  assign event_res_o     = res.event_res;
  assign slot_o          = 5'(res.slot);
  assign prn_o           = res.prn;
  assign elevation_o     = res.elevation;
  assign azimuth_o       = res.azimuth;
  assign snr_o           = res.snr;
  assign constellation_o = res.constellation;
  assign last_o          = res.last;

endmodule

// File: src/gsv_checker.sv
// port-level assertions for the gsv satellite table
module gsv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       kind_i,
  input logic       valid_o,
  input logic       event_res_o,
  input logic [7:0] prn_o,
  input logic [9:0] snr_o,
  input logic       last_o
);

  // an update is always the only word of its byte
  a_update_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !event_res_o |-> last_o) else $error("update without last");

  a_evict_prn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && event_res_o |-> prn_o == 8'd0) else $error("eviction with nonzero prn");

  a_update_prn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !event_res_o |-> prn_o != 8'd0 && prn_o < 8'd200)
    else $error("update with bad prn");

  a_snr_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> snr_o <= 10'd999) else $error("snr above saturation");

  // a tick always starts a sweep
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i |=> busy) else $error("tick did not start sweep");

endmodule

bind gsv_satellite_table gsv_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .kind_i      (kind_i),
  .valid_o     (valid_o),
  .event_res_o (event_res_o),
  .prn_o       (prn_o),
  .snr_o       (snr_o),
  .last_o      (last_o)
);

// File: dv/tb.sv
// testbench for the gsv satellite table: sentence bytes and ticks checked against a predictor
`timescale 1ns / 1ps

module tb;
  import gsv_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int DrainCycles = 40;
  localparam int StallLimit = 4000;

  typedef enum logic [1:0] {PhIdle, PhHeader, PhGroups, PhDone} parse_ph_e;

  typedef struct {
    logic        do_cfg;
    logic [31:0] cfg_val;
    string       text;
    int          ticks;
    int          n_exp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = 1'b0;
  logic [7:0]  char_in_i = 8'h00;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = 32'h0;
  logic        valid_o;
  logic        event_res_o;
  logic [4:0]  slot_o;
  logic [7:0]  prn_o;
  logic [6:0]  elevation_o;
  logic [8:0]  azimuth_o;
  logic [9:0]  snr_o;
  logic [2:0]  constellation_o;
  logic        last_o;

  gsv_satellite_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .char_in_i(char_in_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .valid_o(valid_o), .event_res_o(event_res_o), .slot_o(slot_o), .prn_o(prn_o),
    .elevation_o(elevation_o), .azimuth_o(azimuth_o), .snr_o(snr_o),
    .constellation_o(constellation_o), .last_o(last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // predictor state
  logic [7:0]  sat_prn   [TableEntries];
  logic [6:0]  sat_elev  [TableEntries];
  logic [8:0]  sat_azim  [TableEntries];
  logic [9:0]  sat_snr   [TableEntries];
  logic [2:0]  sat_cons  [TableEntries];
  logic [31:0] sat_stamp [TableEntries];
  logic [31:0] now_ms;
  logic [31:0] timeout_ms;
  parse_ph_e   phase;
  logic [2:0]  cur_cons;
  logic [39:0] prefix_chars;
  logic [3:0]  grp_present;
  int          grp_vals [4];
  int          grp_cnt, prefix_len, comma_cnt, field_no, accum;
  logic        fld_nonempty, fld_neg, fld_stop;

  result_t sat_updates_q[$];
  int      n_predicted;
  int      n_fail;
  int      stall_cnt;
  logic    no_idle;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    n_fail++;
  endtask

  task automatic push_update(input logic ev, input int j);
    result_t r;
    r.event_res = ev;
    r.slot = j[IdxW-1:0];
    r.prn = sat_prn[j];
    r.elevation = sat_elev[j];
    r.azimuth = sat_azim[j];
    r.snr = sat_snr[j];
    r.constellation = sat_cons[j];
    r.last = 1'b0;
    sat_updates_q.push_back(r);
    n_predicted++;
  endtask

  task automatic mark_last();
    result_t r;
    r = sat_updates_q.pop_back();
    r.last = 1'b1;
    sat_updates_q.push_back(r);
  endtask

  task automatic clear_field();
    accum = 0;
    fld_nonempty = 1'b0;
    fld_neg = 1'b0;
    fld_stop = 1'b0;
  endtask

  task automatic store_group();
    int p;
    p = grp_vals[0];
    if (!grp_present[0] || p < 1 || p > 199) return;
    for (int j = 0; j < TableEntries; j++) begin
      if (sat_prn[j] == p || sat_prn[j] == 0) begin
        sat_prn[j] = p[7:0];
        if (grp_present[1] && grp_vals[1] <= 90) sat_elev[j] = grp_vals[1][6:0];
        if (grp_present[2] && grp_vals[2] < 360) sat_azim[j] = grp_vals[2][8:0];
        if (grp_present[3]) sat_snr[j] = grp_vals[3][9:0];
        sat_cons[j] = cur_cons;
        sat_stamp[j] = now_ms;
        push_update(EvUpdate, j);
        mark_last();
        return;
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] ch);
    int fi, v;
    if (ch == ChDollar) begin
      phase = PhHeader;
      cur_cons = ConsUnknown;
      prefix_len = 0;
      comma_cnt = 0;
      grp_cnt = 0;
      field_no = 0;
      grp_present = '0;
      for (int k = 0; k < 4; k++) grp_vals[k] = 0;
      clear_field();
      return;
    end
    if (ch == ChLf) begin
      phase = PhIdle;
      return;
    end
    if (phase == PhIdle || phase == PhDone) return;
    if (prefix_len < 5) begin
      prefix_chars = {prefix_chars[31:0], ch};
      prefix_len++;
      if (prefix_len == 5) begin
        if (prefix_chars == "GPGSV") cur_cons = ConsGps;
        else if (prefix_chars == "GLGSV") cur_cons = ConsGlonass;
        else if (prefix_chars == "GAGSV") cur_cons = ConsGalileo;
        else if (prefix_chars == "BDGSV") cur_cons = ConsBeidou;
        else if (prefix_chars == "QZGSV") cur_cons = ConsQzss;
      end
    end
    if (phase == PhHeader) begin
      if (ch == ChStar) begin
        phase = PhDone;
      end else if (ch == ChComma) begin
        comma_cnt++;
        if (comma_cnt >= 4) begin
          phase = PhGroups;
          field_no = 0;
          grp_present = '0;
          clear_field();
        end
      end
      return;
    end
    if (ch == ChComma || ch == ChStar) begin
      fi = field_no;
      if (fi == 0 && !fld_nonempty && ch == ChStar) begin
        phase = PhDone;
        return;
      end
      grp_vals[fi] = accum;
      if (fld_nonempty && !(fld_neg && accum > 0)) grp_present[fi] = 1'b1;
      if (fi == 3) begin
        store_group();
        grp_cnt++;
        field_no = 0;
        grp_present = '0;
        if (ch == ChStar || grp_cnt >= GroupsPerSentence) phase = PhDone;
      end else begin
        field_no = fi + 1;
        if (ch == ChStar) phase = PhDone;
      end
      clear_field();
      return;
    end
    if (!fld_nonempty && ch == ChMinus) begin
      fld_neg = 1'b1;
    end else if (!fld_stop && ch >= Ch0 && ch <= Ch9) begin
      v = accum * 10 + int'(ch - Ch0);
      accum = (v > int'(AccMax)) ? int'(AccMax) : v;
    end else begin
      fld_stop = 1'b1;
    end
    fld_nonempty = 1'b1;
  endtask

  task automatic predict_tick();
    int n;
    n = 0;
    now_ms = now_ms + 32'd1;
    for (int j = 0; j < TableEntries; j++) begin
      if (sat_prn[j] != 0 && (now_ms - sat_stamp[j]) > timeout_ms) begin
        sat_prn[j] = 8'd0;
        push_update(EvEvict, j);
        n++;
      end
    end
    if (n > 0) mark_last();
  endtask

  // one word to the block, with random idle gaps before it
  task automatic send_word(input logic k, input logic [7:0] ch);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 2);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    kind_i <= k;
    char_in_i <= ch;
    do @(posedge clk_i); while (busy);
    if (k) predict_tick();
    else predict_byte(ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // only written with the block idle and every result in
  task automatic write_timeout(input logic [31:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    while (sat_updates_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_ms = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic string num_field(input int hi);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) return "";
    if (sel < 10) return $sformatf("-%0d", $urandom_range(0, 20));
    if (sel < 14) return $sformatf("%0d", $urandom_range(hi + 1, 99999));
    if (sel < 16) return $sformatf("%0d%c", $urandom_range(0, hi), $urandom_range(33, 126));
    return $sformatf("%0d", $urandom_range(0, hi));
  endfunction

  function automatic string rand_sentence();
    string s, pre;
    int ng, sel;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 6))
      0: pre = "GPGSV";
      1: pre = "GLGSV";
      2: pre = "GAGSV";
      3: pre = "BDGSV";
      4: pre = "QZGSV";
      5: pre = "GNGSV";
      default: pre = $sformatf("%c%cGSV", $urandom_range(65, 90), $urandom_range(65, 90));
    endcase
    if (sel < 12) begin
      s = "";
      repeat ($urandom_range(4, 30)) s = {s, string'(8'($urandom_range(0, 255)))};
      return s;
    end
    s = {"$", pre, $sformatf(",%0d,1,%0d", $urandom_range(1, 4), $urandom_range(0, 16))};
    ng = $urandom_range(0, 5);
    for (int g = 0; g < ng; g++) begin
      if ($urandom_range(0, 99) < 90)
        s = {s, $sformatf(",%0d", $urandom_range(1, 45))};
      else
        s = {s, ",", num_field(250)};
      s = {s, ",", num_field(90), ",", num_field(359), ",", num_field(999)};
    end
    s = {s, ($urandom_range(0, 3) == 0) ? "," : "", "*4F\r\n"};
    // broken sentence: cut short at a random point
    if (sel < 22) s = s.substr(0, $urandom_range(1, s.len() - 1));
    return s;
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && valid_o) begin
      got = '{event_res_o, slot_o, prn_o, elevation_o, azimuth_o, snr_o,
              constellation_o, last_o};
      if (sat_updates_q.size() == 0) begin
        report($sformatf("unexpected word slot %0d prn %0d", slot_o, prn_o));
      end else begin
        want = sat_updates_q.pop_front();
        if (got.event_res != want.event_res)
          report($sformatf("event %0d want %0d", got.event_res, want.event_res));
        if (got.slot != want.slot)
          report($sformatf("slot %0d want %0d", got.slot, want.slot));
        if (got.prn != want.prn)
          report($sformatf("prn %0d want %0d", got.prn, want.prn));
        if (got.elevation != want.elevation)
          report($sformatf("elevation %0d want %0d", got.elevation, want.elevation));
        if (got.azimuth != want.azimuth)
          report($sformatf("azimuth %0d want %0d", got.azimuth, want.azimuth));
        if (got.snr != want.snr)
          report($sformatf("snr %0d want %0d", got.snr, want.snr));
        if (got.constellation != want.constellation)
          report($sformatf("constellation %0d want %0d", got.constellation,
                           want.constellation));
        if (got.last != want.last)
          report($sformatf("last %0d want %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  dir_row_t rows[15];

  initial begin
    int before_cnt;
    logic [31:0] phase_to [3];
    n_fail = 0;
    n_predicted = 0;
    stall_cnt = 0;
    no_idle = 1'b0;
    timeout_ms = TimeoutRst;
    now_ms = '0;
    phase = PhIdle;
    cur_cons = ConsUnknown;
    prefix_chars = '0;
    grp_present = '0;
    grp_cnt = 0;
    prefix_len = 0;
    comma_cnt = 0;
    field_no = 0;
    for (int k = 0; k < 4; k++) grp_vals[k] = 0;
    clear_field();
    for (int j = 0; j < TableEntries; j++) begin
      sat_prn[j] = '0; sat_elev[j] = '0; sat_azim[j] = '0;
      sat_snr[j] = '0; sat_cons[j] = '0; sat_stamp[j] = '0;
    end

    rows[0]  = '{0, 0, "$GPGSV,3,1,11,07,79,048,42,08,90,359,999*5D\r\n", 0, 2};
    rows[1]  = '{0, 0, "$GLGSV,1,1,04,199,-5,,1234,200,10,10,10*", 0, 1};
    rows[2]  = '{0, 0, "$GAGSV,1,1,01,07,91,360,05,30,1,1\n", 0, 1};
    rows[3]  = '{0, 0, "$BDGSV,x,y,z,,1,2,3*", 0, 0};
    rows[4]  = '{0, 0, "$QZGSV,1,1,1,12,1a2,+3, 4,13,1*", 0, 1};
    rows[5]  = '{0, 0, "$GPXXX,1,1,1,20,1,1,1,$GNGSV,1,1,1,21,2,2,2,*", 0, 2};
    rows[6]  = '{0, 0, "ab,12,*\n", 0, 0};
    rows[7]  = '{0, 0, "$GPGSV,1,1,1,-0,,,,*", 0, 0};
    rows[8]  = '{0, 0, "$GPGSV,1,1,1,5,,,-7,6,1,2,3,7,4,5,6,8,7,8,9,9,1,1,1*", 0, 4};
    rows[9]  = '{0, 0, "$GPGSV,1,1,1,5,45,180*", 0, 0};
    rows[10] = '{0, 0, "", 3, 0};
    // timeout set to 1: everything stored is already too old
    rows[11] = '{1, 32'd1, "", 1, 8};
    rows[12] = '{0, 0, "", 1, 0};
    rows[13] = '{1, 32'hFFFF_FFFF, "$GPGSV,1,1,1,40,10,20,30*", 0, 1};
    rows[14] = '{0, 0, "", 2, 0};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].do_cfg) write_timeout(rows[i].cfg_val);
      before_cnt = n_predicted;
      send_text(rows[i].text);
      send_ticks(rows[i].ticks);
      if (n_predicted - before_cnt != rows[i].n_exp)
        report($sformatf("row %0d gave %0d words, table says %0d", i,
                         n_predicted - before_cnt, rows[i].n_exp));
    end

    phase_to[0] = $urandom_range(2, 30);
    phase_to[1] = $urandom_range(50, 400);
    phase_to[2] = 32'd1;
    for (int p = 0; p < 3; p++) begin
      write_timeout(phase_to[p]);
      no_idle = (p == 1);
      for (int n = 0; n < 2; n++) begin
        send_text(rand_sentence());
        send_ticks($urandom_range(0, 6));
      end
    end
    write_timeout(TimeoutRst);
    send_text("$QZGSV,1,1,1,44,90,0,0*\n");

    @(negedge clk_i);
    start <= 1'b0;
    while (sat_updates_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
